FILE: hw/rtl/prad_pkg.sv
// Shared types and constants for the palindrome radius engine.
package prad_pkg;

  localparam int MAX_LEN_DEF     = 1024;
  localparam int SYMBOL_BITS_DEF = 8;

  localparam int OP_W        = 2;
  localparam int SYM_IN_W    = 8;
  localparam int FIELD_W     = 11;
  localparam int STAT_W      = 2;
  localparam int TDATA_IN_W  = 24;
  localparam int TDATA_OUT_W = 24;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic               valid;
    logic [FIELD_W-1:0] pal_length;
    status_t            status;
    logic [FIELD_W-1:0] stored_count;
  } res_t;

endpackage

FILE: hw/rtl/prad_sym_mem.sv
// Symbol store: one write port, two registered read ports.
module prad_sym_mem #(
  parameter int DEPTH = prad_pkg::MAX_LEN_DEF,
  parameter int DW    = prad_pkg::SYMBOL_BITS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: hw/rtl/prad_len_mem.sv
// Radius table: one write port, one registered read port.
module prad_len_mem #(
  parameter int DEPTH = 2 * prad_pkg::MAX_LEN_DEF - 1,
  parameter int DW    = prad_pkg::FIELD_W,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/prad_ctrl.sv
// Command decode, symbol count and the radius sweep sequencer.
module prad_ctrl #(
  parameter int MAX_LEN     = prad_pkg::MAX_LEN_DEF,
  parameter int SYMBOL_BITS = prad_pkg::SYMBOL_BITS_DEF,
  parameter int AW          = $clog2(MAX_LEN),
  parameter int IDX_W       = $clog2(2 * MAX_LEN - 1),
  parameter int POS_W       = $clog2(2 * MAX_LEN)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [prad_pkg::OP_W-1:0]     opcode,
  input  logic [prad_pkg::SYM_IN_W-1:0] symbol,
  input  logic [prad_pkg::FIELD_W-1:0]  query_index,
  input  logic                          even_mode,
  input  logic                          cfg_wen,
  input  logic                          out_free,
  output prad_pkg::res_t                res,
  output logic                          sym_we,
  output logic [AW-1:0]                 sym_waddr,
  output logic [SYMBOL_BITS-1:0]        sym_wdata,
  output logic [AW-1:0]                 sym_raddr_a,
  output logic [AW-1:0]                 sym_raddr_b,
  input  logic [SYMBOL_BITS-1:0]        sym_rdata_a,
  input  logic [SYMBOL_BITS-1:0]        sym_rdata_b,
  output logic                          len_we,
  output logic [IDX_W-1:0]              len_waddr,
  output logic [POS_W-1:0]              len_wdata,
  output logic [IDX_W-1:0]              len_raddr,
  input  logic [POS_W-1:0]              len_rdata
);

  localparam int FW    = prad_pkg::FIELD_W;
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int SUM_W = POS_W + 1;
  localparam int CMP_W = (POS_W > FW) ? POS_W : FW;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_LEN);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_EXPAND   = 7'b0000010,
    S_EXP_CMP  = 7'b0000100,
    S_WRITE_I  = 7'b0001000,
    S_COPY_CHK = 7'b0010000,
    S_COPY_CMP = 7'b0100000,
    S_QREAD    = 7'b1000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             tbl_cur, tbl_cur_next;
  logic [POS_W-1:0] i, i_next, j, j_next, k, k_next;
  logic [POS_W-1:0] n_sw, n_sw_next;
  logic             even_sw, even_sw_next;
  logic [IDX_W-1:0] q_reg, q_reg_next;

  logic                        accept;
  logic [CNT_W:0]              cnt2m1;
  logic [CNT_W+POS_W:0]        n_even_wide;
  logic [CNT_W+POS_W-1:0]      n_odd_wide;
  logic [POS_W-1:0]            n_cur;
  logic [CMP_W+FW-1:0]         q_wide;
  logic [CMP_W+POS_W-1:0]      n_wide;
  logic [CMP_W-1:0]            q_ext, n_ext;
  logic [SYMBOL_BITS+prad_pkg::SYM_IN_W-1:0] sym_wide;
  logic [SUM_W-1:0]            ipj, ipk, kpl, b_pos;
  logic [POS_W-1:0]            imj, imk, a_pos;
  logic [SUM_W-1:0]            two_l_m1, len_sel;
  logic [POS_W-1:0]            even_len;
  logic [SUM_W+FW-1:0]         len_wide;
  logic [CNT_W+FW-1:0]         cnt_wide;

  assign s_tready = (state == S_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  // number of centres for the string as it stands
  assign cnt2m1      = {count, 1'b0} - (CNT_W + 1)'(1);
  assign n_even_wide = {{POS_W{1'b0}}, cnt2m1};
  assign n_odd_wide  = {{POS_W{1'b0}}, count};
  always_comb begin
    if (!even_mode) begin
      n_cur = n_odd_wide[POS_W-1:0];
    end else if (count == '0) begin
      n_cur = '0;
    end else begin
      n_cur = n_even_wide[POS_W-1:0];
    end
  end

  assign q_wide = {{CMP_W{1'b0}}, query_index};
  assign n_wide = {{CMP_W{1'b0}}, n_cur};
  assign q_ext  = q_wide[CMP_W-1:0];
  assign n_ext  = n_wide[CMP_W-1:0];

  assign sym_wide  = {{SYMBOL_BITS{1'b0}}, symbol};
  assign sym_wdata = sym_wide[SYMBOL_BITS-1:0];
  assign sym_waddr = count[AW-1:0];

  assign ipj = {1'b0, i} + {1'b0, j};
  assign ipk = {1'b0, i} + {1'b0, k};
  assign kpl = {1'b0, k} + {1'b0, len_rdata};
  assign imj = i - j;
  assign imk = i - k;

  // in even mode the extended string maps back to stored symbols by halving
  assign a_pos       = even_sw ? (imj >> 1) : imj;
  assign b_pos       = even_sw ? (ipj >> 1) : ipj;
  assign sym_raddr_a = a_pos[AW-1:0];
  assign sym_raddr_b = b_pos[AW-1:0];

  // raw radius to reported length
  assign two_l_m1 = {len_rdata, 1'b0} - SUM_W'(1);
  assign even_len = len_rdata - {{(POS_W-1){1'b0}}, (q_reg[0] == len_rdata[0])};
  assign len_sel  = even_sw ? {1'b0, even_len} : two_l_m1;
  assign len_wide = {{FW{1'b0}}, len_sel};
  assign cnt_wide = {{FW{1'b0}}, count_next};

  always_comb begin
    state_next   = state;
    count_next   = count;
    tbl_cur_next = tbl_cur;
    i_next       = i;
    j_next       = j;
    k_next       = k;
    n_sw_next    = n_sw;
    even_sw_next = even_sw;
    q_reg_next   = q_reg;
    sym_we       = 1'b0;
    len_we       = 1'b0;
    len_waddr    = i[IDX_W-1:0];
    len_wdata    = j;
    len_raddr    = q_reg;
    res.valid    = 1'b0;
    res.status   = prad_pkg::ST_OK;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (prad_pkg::opcode_t'(opcode))
            prad_pkg::OP_CLEAR: begin
              count_next   = '0;
              tbl_cur_next = 1'b0;
              res.valid    = 1'b1;
            end
            prad_pkg::OP_APPEND: begin
              res.valid = 1'b1;
              if (count == FULL) begin
                res.status = prad_pkg::ST_FULL;
              end else begin
                sym_we       = 1'b1;
                count_next   = count + CNT_W'(1);
                tbl_cur_next = 1'b0;
              end
            end
            prad_pkg::OP_QUERY: begin
              if (q_ext >= n_ext) begin
                res.valid  = 1'b1;
                res.status = prad_pkg::ST_RANGE;
              end else begin
                q_reg_next   = q_ext[IDX_W-1:0];
                n_sw_next    = n_cur;
                even_sw_next = even_mode;
                len_raddr    = q_ext[IDX_W-1:0];
                if (tbl_cur) begin
                  state_next = S_QREAD;
                end else begin
                  i_next     = '0;
                  j_next     = '0;
                  state_next = S_EXPAND;
                end
              end
            end
            default: begin
              res.valid = 1'b1;
            end
          endcase
        end
      end
      S_EXPAND: begin
        if (i >= n_sw) begin
          tbl_cur_next = 1'b1;
          len_raddr    = q_reg;
          state_next   = S_QREAD;
        end else if ((j <= i) && (ipj < {1'b0, n_sw})) begin
          // separator positions always match each other
          if (even_sw && imj[0]) begin
            j_next = j + POS_W'(1);
          end else begin
            state_next = S_EXP_CMP;
          end
        end else begin
          state_next = S_WRITE_I;
        end
      end
      S_EXP_CMP: begin
        if (sym_rdata_a == sym_rdata_b) begin
          j_next     = j + POS_W'(1);
          state_next = S_EXPAND;
        end else begin
          state_next = S_WRITE_I;
        end
      end
      S_WRITE_I: begin
        len_we     = 1'b1;
        len_waddr  = i[IDX_W-1:0];
        len_wdata  = j;
        k_next     = POS_W'(1);
        state_next = S_COPY_CHK;
      end
      S_COPY_CHK: begin
        if ((i > k) && (ipk < {1'b0, n_sw})) begin
          len_raddr  = imk[IDX_W-1:0];
          state_next = S_COPY_CMP;
        end else begin
          i_next     = ipk[POS_W-1:0];
          j_next     = j - k;
          state_next = S_EXPAND;
        end
      end
      S_COPY_CMP: begin
        // mirror radius is still inside the current palindrome
        if (kpl < {1'b0, j}) begin
          len_we     = 1'b1;
          len_waddr  = ipk[IDX_W-1:0];
          len_wdata  = len_rdata;
          k_next     = k + POS_W'(1);
          state_next = S_COPY_CHK;
        end else begin
          i_next     = ipk[POS_W-1:0];
          j_next     = j - k;
          state_next = S_EXPAND;
        end
      end
      S_QREAD: begin
        res.valid  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (cfg_wen) begin
      tbl_cur_next = 1'b0;
    end

    res.pal_length   = (state == S_QREAD) ? len_wide[FW-1:0] : '0;
    res.stored_count = cnt_wide[FW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      tbl_cur <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      tbl_cur <= tbl_cur_next;
    end
  end

  always_ff @(posedge clk) begin
    i       <= i_next;
    j       <= j_next;
    k       <= k_next;
    n_sw    <= n_sw_next;
    even_sw <= even_sw_next;
    q_reg   <= q_reg_next;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("symbol count above capacity");

  a_res_slot: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> out_free)
    else $error("result issued with output register occupied");

  a_count_frozen: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (count_next == count))
    else $error("symbol count changed while busy");

  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_QREAD) |-> (i <= n_sw && j <= n_sw))
    else $error("sweep position past last centre");
`endif

endmodule

FILE: hw/rtl/palindrome_radius_engine.sv
// Top level: stream ports, mode register, output register and memories.
//
// Input words carry a command in s_tuser: clear, append a symbol, or query
// the longest palindrome centred at s_tdata query index. Every accepted word
// returns exactly one output word with the length, a status code and the
// number of stored symbols. Clear and append answer straight from idle; a
// query on a current table reads the radius table and then loads the output
// register. The first query after a clear, a successful append or a write of
// even_mode first runs the radius sweep over every centre (n centres in odd
// mode, 2n-1 in even mode); the sweep is paced by the single read port of
// the radius table and the registered symbol reads, one compare in flight
// at a time. Queries out of range answer without a sweep. A result sits in
// the output register until m_tready; a new word is taken in the same cycle
// the old result leaves, and input stalls only while the output is held or
// a query is in work. Reset empties the string, marks the table stale,
// clears even_mode and drops m_tvalid; the memories are not cleared, since
// a stale table is rebuilt by a sweep before any query reads it.
module palindrome_radius_engine #(
  parameter int MAX_LEN     = prad_pkg::MAX_LEN_DEF,
  parameter int SYMBOL_BITS = prad_pkg::SYMBOL_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // symbol [7:0], query_index [18:8], zero pad above
  input  logic [prad_pkg::TDATA_IN_W-1:0]  s_tdata,
  // opcode [1:0]
  input  logic [prad_pkg::OP_W-1:0]        s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // pal_length [10:0], stored_count [21:11], zero pad above
  output logic [prad_pkg::TDATA_OUT_W-1:0] m_tdata,
  // status [1:0]
  output logic [prad_pkg::STAT_W-1:0]      m_tuser,
  input  logic                             cfg_wen,
  input  logic                             cfg_wdata
);

  localparam int FW      = prad_pkg::FIELD_W;
  localparam int SW      = prad_pkg::SYM_IN_W;
  localparam int EXT_LEN = 2 * MAX_LEN - 1;
  localparam int AW      = $clog2(MAX_LEN);
  localparam int IDX_W   = $clog2(EXT_LEN);
  localparam int POS_W   = $clog2(2 * MAX_LEN);
  localparam int PAD_W   = prad_pkg::TDATA_OUT_W - 2 * FW;

  logic                   even_mode;
  logic                   out_free;
  prad_pkg::res_t         res;
  logic                   sym_we;
  logic [AW-1:0]          sym_waddr, sym_raddr_a, sym_raddr_b;
  logic [SYMBOL_BITS-1:0] sym_wdata, sym_rdata_a, sym_rdata_b;
  logic                   len_we;
  logic [IDX_W-1:0]       len_waddr, len_raddr;
  logic [POS_W-1:0]       len_wdata, len_rdata;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      even_mode <= 1'b0;
    end else if (cfg_wen) begin
      even_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      m_tdata <= {{PAD_W{1'b0}}, res.stored_count, res.pal_length};
      m_tuser <= res.status;
    end
  end

  prad_ctrl #(
    .MAX_LEN     (MAX_LEN),
    .SYMBOL_BITS (SYMBOL_BITS),
    .AW          (AW),
    .IDX_W       (IDX_W),
    .POS_W       (POS_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .opcode      (s_tuser),
    .symbol      (s_tdata[SW-1:0]),
    .query_index (s_tdata[SW+FW-1:SW]),
    .even_mode   (even_mode),
    .cfg_wen     (cfg_wen),
    .out_free    (out_free),
    .res         (res),
    .sym_we      (sym_we),
    .sym_waddr   (sym_waddr),
    .sym_wdata   (sym_wdata),
    .sym_raddr_a (sym_raddr_a),
    .sym_raddr_b (sym_raddr_b),
    .sym_rdata_a (sym_rdata_a),
    .sym_rdata_b (sym_rdata_b),
    .len_we      (len_we),
    .len_waddr   (len_waddr),
    .len_wdata   (len_wdata),
    .len_raddr   (len_raddr),
    .len_rdata   (len_rdata)
  );

  prad_sym_mem #(
    .DEPTH (MAX_LEN),
    .DW    (SYMBOL_BITS),
    .AW    (AW)
  ) u_sym_mem (
    .clk     (clk),
    .we      (sym_we),
    .waddr   (sym_waddr),
    .wdata   (sym_wdata),
    .raddr_a (sym_raddr_a),
    .raddr_b (sym_raddr_b),
    .rdata_a (sym_rdata_a),
    .rdata_b (sym_rdata_b)
  );

  prad_len_mem #(
    .DEPTH (EXT_LEN),
    .DW    (POS_W),
    .AW    (IDX_W)
  ) u_len_mem (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

endmodule
